// File: rtl/core/pfts_pkg.sv
// Package for the page frame table: shared types, codes and constants.
// Used by pfts_cell and page_frame_table_with_replacement_top.
`default_nettype none
package pfts_pkg;

    localparam int NUM_FRAMES_DEF = 16;
    localparam int IDX_W          = 6;
    localparam int PAGE_W         = 31;
    localparam int STAMP_W        = 32;
    localparam int PIN_W          = 8;
    localparam int CNT_W          = 32;
    localparam int MAX_OUT        = 16;
    localparam logic [PIN_W-1:0] PIN_MAX = '1;

    typedef enum logic [2:0] {
        ACT_PIN   = 3'd0,
        ACT_UNPIN = 3'd1,
        ACT_DIRTY = 3'd2,
        ACT_FLUSH = 3'd3,
        ACT_FORCE = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ABSENT     = 2'd1,
        ST_ALL_PINNED = 2'd2,
        ST_UNDERFLOW  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DECIDE,
        FSM_OUT
    } fsm_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_HIT,
        CMD_PIN_DEC,
        CMD_DIRTY_SET,
        CMD_DIRTY_CLR
    } cmd_kind_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [PAGE_W-1:0] page_num;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [3:0]        frame_index;
        logic              hit;
        logic              write_back;
        logic [PAGE_W-1:0] write_page;
        logic              load;
        logic [CNT_W-1:0]  read_count;
        logic [CNT_W-1:0]  write_count;
        logic              last;
    } out_item_t;

    // Search packet that travels along the row of frame cells.
    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic               match_found;
        logic [IDX_W-1:0]   match_idx;
        logic [PIN_W-1:0]   match_pin;
        logic               empty_found;
        logic [IDX_W-1:0]   empty_idx;
        logic               vic_found;
        logic [IDX_W-1:0]   vic_idx;
        logic [STAMP_W-1:0] vic_stamp;
        logic               vic_dirty;
        logic [PAGE_W-1:0]  vic_page;
        logic               fl_found;
        logic [IDX_W-1:0]   fl_idx;
        logic [PAGE_W-1:0]  fl_page;
        logic               fl_second;
    } scan_pkt_t;

    // Update broadcast to all cells; only the addressed cell acts on it.
    typedef struct packed {
        cmd_kind_t          kind;
        logic [IDX_W-1:0]   idx;
        logic [PAGE_W-1:0]  page;
        logic [STAMP_W-1:0] stamp;
        logic               stamp_en;
    } cell_cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/page_frame_table_with_replacement_top.sv
// Top level of the page frame table with FIFO or LRU replacement.
// Depends on pfts_pkg and pfts_cell.
`default_nettype none
// The table keeps NUM_FRAMES frames, one per cell in a row. Every operation
// sends a search packet down the row, one cell per clock; the packet leaves
// the row knowing the matching frame, the lowest empty frame, the
// replacement victim and the next frame to flush. The decision state then
// broadcasts the update to the chosen cell and loads the result register,
// which holds the beat until the output side takes it. The next input beat
// can be taken in the cycle after the output beat, so the table works on
// one item at a time. A flush repeats the scan once per flushed frame. The
// policy register may be written at any time the table is idle; its port is
// always ready.
module page_frame_table_with_replacement_top #(
    parameter int NUM_FRAMES = pfts_pkg::NUM_FRAMES_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  pfts_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output pfts_pkg::out_item_t out_data,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire                 cfg_data
);

    localparam int SCW = (NUM_FRAMES > 2) ? $clog2(NUM_FRAMES) : 1;
    localparam logic [SCW-1:0] SCAN_LAST = SCW'(NUM_FRAMES - 1);
    localparam int NW = $clog2(pfts_pkg::MAX_OUT);

    pfts_pkg::fsm_t                 state_reg, state_next;
    logic                           policy_reg;
    logic [2:0]                     action_reg;
    logic [pfts_pkg::PAGE_W-1:0]    page_reg;
    logic [SCW-1:0]                 scan_cnt_reg, scan_cnt_next;
    logic [NW-1:0]                  flush_n_reg, flush_n_next;
    logic [pfts_pkg::STAMP_W-1:0]   stamp_reg, stamp_next;
    logic [pfts_pkg::CNT_W-1:0]     loads_reg, loads_next;
    logic [pfts_pkg::CNT_W-1:0]     writes_reg, writes_next;
    pfts_pkg::out_item_t            res_reg, res_next;
    pfts_pkg::cell_cmd_t            cmd, cmd_calc;
    pfts_pkg::scan_pkt_t            pkt_w [NUM_FRAMES+1];
    pfts_pkg::scan_pkt_t            res_pkt;
    logic                           in_fire, out_fire, decide;

    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign decide    = (state_reg == pfts_pkg::FSM_DECIDE);
    assign cfg_ready = 1'b1;
    assign out_data  = res_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfts_pkg::FSM_IDLE:
                if (in_valid) state_next = pfts_pkg::FSM_SCAN;
            pfts_pkg::FSM_SCAN:
                if (scan_cnt_reg == SCAN_LAST) state_next = pfts_pkg::FSM_DECIDE;
            pfts_pkg::FSM_DECIDE:
                state_next = pfts_pkg::FSM_OUT;
            pfts_pkg::FSM_OUT:
                if (out_ready)
                begin
                    state_next = res_reg.last ? pfts_pkg::FSM_IDLE : pfts_pkg::FSM_SCAN;
                end
            default:
                state_next = pfts_pkg::FSM_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        in_ready  = (state_reg == pfts_pkg::FSM_IDLE);
        out_valid = (state_reg == pfts_pkg::FSM_OUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pfts_pkg::FSM_IDLE;
            policy_reg   <= 1'b0;
            scan_cnt_reg <= '0;
            flush_n_reg  <= '0;
            stamp_reg    <= '0;
            loads_reg    <= '0;
            writes_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            flush_n_reg  <= flush_n_next;
            stamp_reg    <= stamp_next;
            loads_reg    <= loads_next;
            writes_reg   <= writes_next;
            if (cfg_valid && cfg_ready)
            begin
                policy_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            action_reg <= in_data.action;
            page_reg   <= in_data.page_num;
        end
        if (decide)
        begin
            res_reg <= res_next;
        end
    end

    always_comb
    begin
        scan_cnt_next = '0;
        if (state_reg == pfts_pkg::FSM_SCAN)
        begin
            scan_cnt_next = scan_cnt_reg + SCW'(1);
        end
        flush_n_next = flush_n_reg;
        if (in_fire)
        begin
            flush_n_next = '0;
        end
        else if (out_fire)
        begin
            flush_n_next = flush_n_reg + NW'(1);
        end
    end

    // The row of cells. The launch packet is constant while a scan runs.
    always_comb
    begin
        pkt_w[0]      = '0;
        pkt_w[0].page = page_reg;
    end

    for (genvar i = 0; i < NUM_FRAMES; i++)
    begin : g_cell
        pfts_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .pkt_in  (pkt_w[i]),
            .pkt_out (pkt_w[i+1]),
            .cmd     (cmd)
        );
    end

    assign res_pkt = pkt_w[NUM_FRAMES];

    // Decision on the finished packet: the result beat, the cell update and
    // the counters. Only applied in the decision cycle.
    always_comb
    begin
        res_next             = '0;
        res_next.last        = 1'b1;
        res_next.status      = pfts_pkg::ST_OK;
        cmd_calc             = '0;
        cmd_calc.kind        = pfts_pkg::CMD_NONE;
        cmd_calc.page        = page_reg;
        cmd_calc.stamp       = stamp_reg;
        stamp_next           = stamp_reg;
        loads_next           = loads_reg;
        writes_next          = writes_reg;

        case (action_reg)
            pfts_pkg::ACT_PIN:
            begin
                if (res_pkt.match_found)
                begin
                    cmd_calc.kind        = pfts_pkg::CMD_HIT;
                    cmd_calc.idx         = res_pkt.match_idx;
                    cmd_calc.stamp_en    = policy_reg;
                    if (policy_reg)
                    begin
                        stamp_next = stamp_reg + pfts_pkg::STAMP_W'(1);
                    end
                    res_next.frame_index = res_pkt.match_idx[3:0];
                    res_next.hit         = 1'b1;
                end
                else if (res_pkt.empty_found || res_pkt.vic_found)
                begin
                    cmd_calc.kind = pfts_pkg::CMD_LOAD;
                    cmd_calc.idx  = res_pkt.empty_found ? res_pkt.empty_idx
                                                        : res_pkt.vic_idx;
                    stamp_next    = stamp_reg + pfts_pkg::STAMP_W'(1);
                    loads_next    = loads_reg + pfts_pkg::CNT_W'(1);
                    if (!res_pkt.empty_found && res_pkt.vic_dirty)
                    begin
                        res_next.write_back = 1'b1;
                        res_next.write_page = res_pkt.vic_page;
                        writes_next         = writes_reg + pfts_pkg::CNT_W'(1);
                    end
                    res_next.frame_index = cmd_calc.idx[3:0];
                    res_next.load        = 1'b1;
                end
                else
                begin
                    res_next.status = pfts_pkg::ST_ALL_PINNED;
                end
            end
            pfts_pkg::ACT_UNPIN:
            begin
                if (!res_pkt.match_found)
                begin
                    res_next.status = pfts_pkg::ST_ABSENT;
                end
                else if (res_pkt.match_pin == '0)
                begin
                    res_next.status = pfts_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    cmd_calc.kind        = pfts_pkg::CMD_PIN_DEC;
                    cmd_calc.idx         = res_pkt.match_idx;
                    res_next.frame_index = res_pkt.match_idx[3:0];
                end
            end
            pfts_pkg::ACT_DIRTY:
            begin
                if (!res_pkt.match_found)
                begin
                    res_next.status = pfts_pkg::ST_ABSENT;
                end
                else
                begin
                    cmd_calc.kind        = pfts_pkg::CMD_DIRTY_SET;
                    cmd_calc.idx         = res_pkt.match_idx;
                    res_next.frame_index = res_pkt.match_idx[3:0];
                end
            end
            pfts_pkg::ACT_FORCE:
            begin
                if (!res_pkt.match_found)
                begin
                    res_next.status = pfts_pkg::ST_ABSENT;
                end
                else
                begin
                    cmd_calc.kind        = pfts_pkg::CMD_DIRTY_CLR;
                    cmd_calc.idx         = res_pkt.match_idx;
                    writes_next          = writes_reg + pfts_pkg::CNT_W'(1);
                    res_next.frame_index = res_pkt.match_idx[3:0];
                    res_next.write_back  = 1'b1;
                    res_next.write_page  = page_reg;
                end
            end
            pfts_pkg::ACT_FLUSH:
            begin
                // Each pass flushes the lowest candidate; clearing its dirty
                // bit lets the next pass find the following one.
                if (res_pkt.fl_found)
                begin
                    cmd_calc.kind        = pfts_pkg::CMD_DIRTY_CLR;
                    cmd_calc.idx         = res_pkt.fl_idx;
                    writes_next          = writes_reg + pfts_pkg::CNT_W'(1);
                    res_next.frame_index = res_pkt.fl_idx[3:0];
                    res_next.write_back  = 1'b1;
                    res_next.write_page  = res_pkt.fl_page;
                    res_next.last        = !res_pkt.fl_second ||
                                           (flush_n_reg == NW'(pfts_pkg::MAX_OUT - 1));
                end
            end
            default: ;
        endcase
        res_next.read_count  = loads_next;
        res_next.write_count = writes_next;

        if (!decide)
        begin
            stamp_next  = stamp_reg;
            loads_next  = loads_reg;
            writes_next = writes_reg;
        end
    end

    always_comb
    begin
        cmd = cmd_calc;
        if (!decide)
        begin
            cmd.kind = pfts_pkg::CMD_NONE;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/pfts_cell.sv
// One frame of the page frame table: holds the frame state and folds it
// into the search packet passing by. Depends on pfts_pkg.
`default_nettype none
module pfts_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  pfts_pkg::scan_pkt_t  pkt_in,
    output pfts_pkg::scan_pkt_t  pkt_out,
    input  pfts_pkg::cell_cmd_t  cmd
);

    localparam logic [pfts_pkg::IDX_W-1:0] MY_IDX = pfts_pkg::IDX_W'(CELL_IDX);

    logic                            valid_reg;
    logic                            dirty_reg;
    logic [pfts_pkg::PIN_W-1:0]      pin_reg;
    logic [pfts_pkg::PAGE_W-1:0]     page_reg;
    logic [pfts_pkg::STAMP_W-1:0]    stamp_reg;
    pfts_pkg::scan_pkt_t             pkt_next;
    pfts_pkg::scan_pkt_t             pkt_reg;
    logic                            sel;

    assign sel = (cmd.idx == MY_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            pin_reg   <= '0;
        end
        else if (sel)
        begin
            case (cmd.kind)
                pfts_pkg::CMD_LOAD:
                begin
                    valid_reg <= 1'b1;
                    dirty_reg <= 1'b0;
                    pin_reg   <= pfts_pkg::PIN_W'(1);
                end
                pfts_pkg::CMD_HIT:
                begin
                    if (pin_reg != pfts_pkg::PIN_MAX)
                    begin
                        pin_reg <= pin_reg + pfts_pkg::PIN_W'(1);
                    end
                end
                pfts_pkg::CMD_PIN_DEC:   pin_reg   <= pin_reg - pfts_pkg::PIN_W'(1);
                pfts_pkg::CMD_DIRTY_SET: dirty_reg <= 1'b1;
                pfts_pkg::CMD_DIRTY_CLR: dirty_reg <= 1'b0;
                default:                 ;
            endcase
        end
    end

    // Page and stamp carry no reset; the victim check reads them even for empty frames.
    always_ff @(posedge clk)
    begin
        if (sel && cmd.kind == pfts_pkg::CMD_LOAD)
        begin
            page_reg <= cmd.page;
        end
        if (sel && (cmd.kind == pfts_pkg::CMD_LOAD ||
                    (cmd.kind == pfts_pkg::CMD_HIT && cmd.stamp_en)))
        begin
            stamp_reg <= cmd.stamp;
        end
    end

    always_comb
    begin
        pkt_next = pkt_in;
        if (valid_reg && page_reg == pkt_in.page && !pkt_in.match_found)
        begin
            pkt_next.match_found = 1'b1;
            pkt_next.match_idx   = MY_IDX;
            pkt_next.match_pin   = pin_reg;
        end
        if (!valid_reg && !pkt_in.empty_found)
        begin
            pkt_next.empty_found = 1'b1;
            pkt_next.empty_idx   = MY_IDX;
        end
        // Strict compare keeps the lowest index on equal stamps.
        if (pin_reg == '0 && (!pkt_in.vic_found || stamp_reg < pkt_in.vic_stamp))
        begin
            pkt_next.vic_found = 1'b1;
            pkt_next.vic_idx   = MY_IDX;
            pkt_next.vic_stamp = stamp_reg;
            pkt_next.vic_dirty = dirty_reg;
            pkt_next.vic_page  = page_reg;
        end
        if (valid_reg && dirty_reg && pin_reg == '0)
        begin
            if (!pkt_in.fl_found)
            begin
                pkt_next.fl_found = 1'b1;
                pkt_next.fl_idx   = MY_IDX;
                pkt_next.fl_page  = page_reg;
            end
            else
            begin
                pkt_next.fl_second = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pkt_reg <= pkt_next;
    end

    assign pkt_out = pkt_reg;

endmodule
`default_nettype wire
